// ===== rtl/core/lkv_pkg.sv =====
// Package for the LRU key-value cache.
// Holds field widths, reset constants and the result record shared by the
// sequencer and the top level. No dependencies.
package lkv_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // One result item as it leaves the sequencer.
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_data;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } lkv_res_t;

endpackage

// ===== rtl/core/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: capacity register, sequencer and
// entry memory. Depends on lkv_pkg, lkv_ctrl and lkv_store.
//
// Usage: items arrive on the in_ channel (in_action, in_key,
// in_write_data) and are transferred when in_valid is high and in_stall
// low. Each item yields exactly one result on the out_ channel (hit,
// read_data, evicted, evicted_key), transferred when out_valid is high and
// out_stall low. The capacity register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce.
// The block takes no new item until the previous one has moved into the
// output register. Each item sweeps the entry memory once to search it
// and, on a get hit or an add of a new key, once more to rewrite recency
// ranks, one entry per cycle through the single memory read port; these
// sweeps set the rate.
// Reset marks all entries invalid, clears the fill count and the output
// valid flag, and sets the capacity to ten. A stalled result is held in
// the output register while the next item is already searched; the item
// finishes only once the output register is free.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_evicted,
  output logic [KEY_W-1:0]  out_evicted_key
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = KEY_W + DATA_W + AW;

  logic [CAP_W-1:0] cap_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [DW-1:0]    rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DW-1:0]    wr_data;
  lkv_res_t         res;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  lkv_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cap           (cap_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_key        (in_key),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (res),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  lkv_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Unpack the result record onto the ports.
  assign out_hit         = res.hit;
  assign out_read_data   = res.read_data;
  assign out_evicted     = res.evicted;
  assign out_evicted_key = res.evicted_key;

endmodule

// ===== rtl/core/lkv_store.sv =====
// Entry memory of the LRU key-value cache: key, value and recency rank per
// entry. One read port with registered data and one write port.
// Depends on nothing but its parameters.
module lkv_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 68
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Synchronous read with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/lkv_ctrl.sv =====
// Sequencer of the LRU key-value cache: a search sweep over the entry
// memory, an update sweep that rewrites ranks, and the output register.
// Depends on lkv_pkg; drives the ports of lkv_store.
module lkv_ctrl
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CAP_W-1:0]  cap,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lkv_res_t          out_res,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [KEY_W+DATA_W+AW-1:0] rd_data,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [KEY_W+DATA_W+AW-1:0] wr_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);
  localparam logic [EW-1:0] MAX_CAP   = EW'(MAX_ENTRIES);

  logic [1:0]        state_r;
  logic              iss_r;
  logic [AW-1:0]     addr_r;
  logic              p_vld_r;
  logic [AW-1:0]     p_addr_r;
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [CW-1:0]     count_r;

  logic              act_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] wdata_r;

  logic              found_r;
  logic [AW-1:0]     pos_r;
  logic [AW-1:0]     pos_rank_r;
  logic [DATA_W-1:0] val_r;
  logic              lru_ok_r;
  logic [AW-1:0]     lru_r;
  logic [AW-1:0]     lru_rank_r;
  logic [KEY_W-1:0]  lru_key_r;
  logic              free_ok_r;
  logic [AW-1:0]     free_r;
  logic              evict_r;

  logic              out_valid_r;
  lkv_res_t          out_res_r;

  logic [KEY_W-1:0]  e_key;
  logic [DATA_W-1:0] e_val;
  logic [AW-1:0]     e_rank;
  logic              e_vld;
  logic              last_ret;
  logic              found_c;
  logic              lru_ok_c;
  logic              done_go;
  logic [EW-1:0]     cap_x;
  logic [EW-1:0]     eff_cap;
  logic              do_evict;
  logic [AW-1:0]     slot;

  assign {e_key, e_val, e_rank} = rd_data;
  assign e_vld    = valid_r[p_addr_r];
  assign last_ret = p_vld_r && (p_addr_r == LAST_ADDR);

  // Search results including the entry returned in this cycle.
  assign found_c  = found_r || (p_vld_r && e_vld && (e_key == key_r));
  assign lru_ok_c = lru_ok_r || (p_vld_r && e_vld);

  // Effective capacity: zero acts as one, above the depth saturates.
  assign cap_x    = EW'(cap);
  assign eff_cap  = (cap == '0) ? EW'(1) : ((cap_x > MAX_CAP) ? MAX_CAP : cap_x);
  assign do_evict = (EW'(count_r) >= eff_cap) && (count_r != '0) && lru_ok_c;

  // Insertion slot: lowest free entry after the eviction.
  assign slot = (evict_r && (!free_ok_r || lru_r < free_r)) ? lru_r : free_r;

  // The finished item moves into the output register once it is free.
  assign done_go = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != ST_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign rd_en     = iss_r;
  assign rd_addr   = addr_r;
  assign wr_addr   = p_addr_r;
  assign wr_en     = p_vld_r && (state_r == ST_UPD);

  // Rewritten entry during the update sweep.
  always_comb begin
    wr_data = rd_data;
    if (act_r == ACT_GET) begin
      if (p_addr_r == pos_r) begin
        wr_data = {e_key, e_val, AW'(0)};
      end else if (e_vld && e_rank < pos_rank_r) begin
        wr_data = {e_key, e_val, AW'(e_rank + AW'(1))};
      end
    end else begin
      if (p_addr_r == slot) begin
        wr_data = {key_r, wdata_r, AW'(0)};
      end else if (e_vld) begin
        wr_data = {e_key, e_val, AW'(e_rank + AW'(1))};
      end
    end
  end

  // Sequencer, read pipeline and entry bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= 1'b0;
      p_vld_r     <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p_vld_r  <= iss_r;
      p_addr_r <= addr_r;
      if (iss_r) begin
        addr_r <= AW'(addr_r + AW'(1));
        if (addr_r == LAST_ADDR) begin
          iss_r <= 1'b0;
        end
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r     <= in_action;
            key_r     <= in_key;
            wdata_r   <= in_write_data;
            found_r   <= 1'b0;
            lru_ok_r  <= 1'b0;
            free_ok_r <= 1'b0;
            evict_r   <= 1'b0;
            iss_r     <= 1'b1;
            addr_r    <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (p_vld_r) begin
            if (e_vld && e_key == key_r) begin
              found_r    <= 1'b1;
              pos_r      <= p_addr_r;
              pos_rank_r <= e_rank;
              val_r      <= e_val;
            end
            if (e_vld && (!lru_ok_r || e_rank > lru_rank_r)) begin
              lru_ok_r   <= 1'b1;
              lru_r      <= p_addr_r;
              lru_rank_r <= e_rank;
              lru_key_r  <= e_key;
            end
            if (!e_vld && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r    <= p_addr_r;
            end
          end
          if (last_ret) begin
            if (act_r == ACT_GET && found_c) begin
              iss_r   <= 1'b1;
              addr_r  <= '0;
              state_r <= ST_UPD;
            end else if (act_r == ACT_ADD && !found_c) begin
              evict_r <= do_evict;
              if (!do_evict) begin
                count_r <= CW'(count_r + CW'(1));
              end
              iss_r   <= 1'b1;
              addr_r  <= '0;
              state_r <= ST_UPD;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_UPD: begin
          if (p_vld_r && act_r == ACT_ADD) begin
            if (p_addr_r == slot) begin
              valid_r[p_addr_r] <= 1'b1;
            end else if (evict_r && p_addr_r == lru_r) begin
              valid_r[p_addr_r] <= 1'b0;
            end
          end
          if (last_ret) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (done_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register, loaded when the item finishes.
  always_ff @(posedge clk) begin
    if (done_go) begin
      out_res_r.hit         <= found_r;
      out_res_r.read_data   <= (act_r == ACT_GET && found_r) ? val_r : '0;
      out_res_r.evicted     <= evict_r;
      out_res_r.evicted_key <= evict_r ? lru_key_r : '0;
    end
  end

endmodule

// ===== rtl/core/lkv_checker.sv =====
// Port-level checks for the LRU key-value cache and the bind that attaches
// them to lru_key_value_cache. Depends on lkv_pkg.
module lkv_checker
  import lkv_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [DATA_W-1:0] out_read_data,
  input logic              out_evicted,
  input logic [KEY_W-1:0]  out_evicted_key
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // An eviction only happens on an add of a new key.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit)
    else $error("eviction reported together with a hit");

  // Without an eviction the evicted key reads zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key set without an eviction");

  // Nonzero read data needs a hit.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != '0 |-> out_hit)
    else $error("read data returned on a miss");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_read_data   (out_read_data),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);

// ===== dv/lru_key_value_cache_tb.sv =====
// Self-checking testbench for the LRU key-value cache.
// Predicts every result with its own cache model and checks it field by field.
// Depends on lkv_pkg and lru_key_value_cache.
module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int TIMEOUT_CYCLES = 20000;
  localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 10;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [KEY_W-1:0]  in_key;
  logic [DATA_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_data;
  logic              out_evicted;
  logic [KEY_W-1:0]  out_evicted_key;

  lru_key_value_cache #(.MAX_ENTRIES(NUM_SLOTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_key(in_key), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_read_data(out_read_data), .out_evicted(out_evicted),
    .out_evicted_key(out_evicted_key)
  );

  // Shadow copy of the cache contents.
  logic              shadow_valid [NUM_SLOTS];
  logic [KEY_W-1:0]  shadow_key   [NUM_SLOTS];
  logic [DATA_W-1:0] shadow_value [NUM_SLOTS];
  int unsigned       shadow_rank  [NUM_SLOTS];
  int unsigned       shadow_count;
  logic [CAP_W-1:0]  shadow_capacity;

  lkv_res_t    pending_results[$];
  logic [KEY_W-1:0] key_pool[$];
  int          error_count;
  int          idle_cycles;
  bit          hold_output;
  int          hold_cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Computes the result of one item and advances the shadow cache.
  function automatic lkv_res_t predict_access(logic act, logic [KEY_W-1:0] k,
                                              logic [DATA_W-1:0] d);
    lkv_res_t res;
    int pos;
    int lru;
    int slot;
    int unsigned cap;
    int unsigned best;
    int unsigned r;
    res = '0;
    pos = -1;
    lru = -1;
    slot = -1;
    best = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (pos < 0 && shadow_valid[i] && shadow_key[i] == k) pos = i;
    end
    cap = (shadow_capacity == 0) ? 1 : shadow_capacity;
    if (cap > NUM_SLOTS) cap = NUM_SLOTS;
    if (act == ACT_GET) begin
      if (pos >= 0) begin
        r = shadow_rank[pos];
        res.hit = 1'b1;
        res.read_data = shadow_value[pos];
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
        end
        shadow_rank[pos] = 0;
      end
    end else if (pos >= 0) begin
      res.hit = 1'b1;
    end else begin
      // Evict the least recent entry when the cache is full.
      if (shadow_count >= cap && shadow_count > 0) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (shadow_valid[i] && (lru < 0 || shadow_rank[i] > best)) begin
            lru = i;
            best = shadow_rank[i];
          end
        end
        res.evicted = 1'b1;
        res.evicted_key = shadow_key[lru];
        shadow_valid[lru] = 1'b0;
        shadow_rank[lru] = 0;
        shadow_count--;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (shadow_valid[i]) shadow_rank[i]++;
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot] = k;
      shadow_value[slot] = d;
      shadow_rank[slot] = 0;
      shadow_count++;
    end
    return res;
  endfunction

  // Sends one item after a random gap and records its expected result.
  // Valid stays high after the transfer so the next item can follow at once.
  task automatic send_item(logic act, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d,
                           bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 19) : 0);
    if (gap != 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_write_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_access(act, k, d));
    if (act == ACT_ADD) key_pool.push_back(k);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if ($urandom_range(0, 1)) return KEY_W'($urandom_range(0, 40));
    return $urandom;
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) begin
      send_item(1'($urandom_range(0, 1)), pick_key(), $urandom);
    end
  endtask

  // Extremes of key and data, gets of present and missing keys, repeat adds.
  task automatic test_directed();
    send_item(ACT_GET, 32'h0000_0000, 32'h0);
    send_item(ACT_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h0000_0000);
    send_item(ACT_ADD, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_item(ACT_ADD, 32'h0000_0000, 32'h5A5A_A5A5);
    send_item(ACT_ADD, 32'h8000_0000, 32'h1234_5678);
    send_item(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(ACT_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_GET, 32'h0000_0001, 32'h0);
    for (int i = 1; i <= 10; i++) send_item(ACT_ADD, i * 3, 32'hC000_0000 + i);
    send_item(ACT_GET, 32'h0000_0000, 32'h0);
    send_item(ACT_ADD, 32'h0000_1000, 32'h0);
  endtask

  // Capacity zero, one, the maximum and above it, and lowering below the fill.
  task automatic test_capacity_sweep();
    logic [CAP_W-1:0] caps[6];
    caps = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd10};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      send_random(40);
    end
    key_pool.delete();
    write_capacity(5'd16);
    for (int i = 0; i < 16; i++) send_item(ACT_ADD, 32'h100 + i, $urandom);
    write_capacity(5'd2);
    send_random(30);
  endtask

  // Receiver holds off while items keep coming; then the sender waits for all.
  task automatic test_backpressure();
    write_capacity(5'd8);
    hold_cycles = 300;
    hold_output = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_item(1'($urandom_range(0, 1)), pick_key(), $urandom, 1);
    end
    wait_idle();
    send_random(20);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 8; phase++) begin
      write_capacity(CAP_W'($urandom_range(0, 31)));
      if (key_pool.size() > 64) key_pool = key_pool[key_pool.size() - 32:$];
      send_random(26);
    end
  endtask

  // Receiver stall: random per result, or a long hold-off when requested.
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_output = 1'b0;
      end
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compares each transferred result with the oldest expectation.
  always @(posedge clk) begin
    lkv_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result hit=%0b data=%h", $time, out_hit, out_read_data);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_hit !== exp_res.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_res.hit, out_hit);
          error_count++;
        end
        if (out_read_data !== exp_res.read_data) begin
          $display("%0t: read_data expected %h actual %h", $time, exp_res.read_data,
                   out_read_data);
          error_count++;
        end
        if (out_evicted !== exp_res.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, exp_res.evicted,
                   out_evicted);
          error_count++;
        end
        if (out_evicted_key !== exp_res.evicted_key) begin
          $display("%0t: evicted_key expected %h actual %h", $time, exp_res.evicted_key,
                   out_evicted_key);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= TIMEOUT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_action = ACT_ADD;
    in_key = '0;
    in_write_data = '0;
    error_count = 0;
    idle_cycles = 0;
    hold_output = 1'b0;
    hold_cycles = 0;
    shadow_count = 0;
    shadow_capacity = CAP_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
      shadow_rank[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_capacity_sweep();
    test_backpressure();
    test_random_mix();
    wait_idle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
